// ===== rtl/core/scc_pkg.sv =====
// Types, constants and helper functions shared by the spherical converter.
`timescale 1ns / 1ps
package scc_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int VW         = 44;   // working width, 8 guard bits
  localparam int AW         = 35;   // angle width, 24 fraction bits
  localparam int KW         = 30;   // gain constant width
  localparam int GUARD      = 8;

  localparam logic [KW-1:0] INV_GAIN = 30'd652032874;

  // unsigned angle reduction, Q16 degrees
  localparam logic [32:0] DEG360_U   = 33'd23592960;
  localparam logic [32:0] RED_OFFSET = 33'd2170552320;   // 92 turns

  localparam logic signed [AW-1:0] DEG90_Q16  = 35'sd5898240;
  localparam logic signed [AW-1:0] DEG180_Q16 = 35'sd11796480;
  localparam logic signed [AW-1:0] DEG360_Q16 = 35'sd23592960;
  localparam logic signed [AW-1:0] DEG180_Q24 = 35'sd3019898880;

  localparam logic signed [DATA_WIDTH-1:0] ONE_Q16 = 32'sh0001_0000;

  localparam logic signed [VW-GUARD:0] SAT_HI =
    {{(VW-GUARD+1-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [VW-GUARD:0] SAT_LO =
    {{(VW-GUARD+1-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

  // atan(2^-i) in degrees, 24 fraction bits
  localparam logic [29:0] ATAN_TAB [0:31] = '{
    30'd754974720, 30'd445687602, 30'd235489089, 30'd119537938, 30'd60000934,
    30'd30029717, 30'd15018523, 30'd7509719, 30'd3754917, 30'd1877466,
    30'd938734, 30'd469367, 30'd234684, 30'd117342, 30'd58671, 30'd29335,
    30'd14668, 30'd7334, 30'd3667, 30'd1833, 30'd917, 30'd458, 30'd229,
    30'd115, 30'd57, 30'd29, 30'd14, 30'd7, 30'd4, 30'd2, 30'd1, 30'd0
  };

  // degain step positions
  localparam int DG_PRE  = 0;
  localparam int DG_MID  = 1;
  localparam int DG_POST = 2;

  typedef enum logic {
    MODE_P2C = 1'b0,
    MODE_C2P = 1'b1
  } mode_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] coord_a;
    logic signed [DATA_WIDTH-1:0] coord_b;
    logic signed [DATA_WIDTH-1:0] coord_c;
    logic [1:0]                   values_given;
  } coord_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] out_a;
    logic signed [DATA_WIDTH-1:0] out_b;
    logic signed [DATA_WIDTH-1:0] out_c;
  } result_t;

  typedef struct packed {
    mode_t                        mode;
    logic signed [DATA_WIDTH-1:0] a;
    logic signed [DATA_WIDTH-1:0] b;
    logic signed [DATA_WIDTH-1:0] c;
    logic [32:0]                  ua;
    logic [32:0]                  ub;
  } prep_t;

  typedef struct packed {
    mode_t                mode;
    logic                 skip;
    logic                 neg1;
    logic                 neg2;
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] hold;
    logic signed [AW-1:0] z;
    logic signed [AW-1:0] ang2;
    logic signed [AW-1:0] az;
  } work_t;

  typedef struct packed {
    logic                 neg;
    logic signed [AW-1:0] ang;
  } fold_t;

  // [0,360) -> [-90,90] with half-turn flag, result in 24 fraction bits
  function automatic fold_t fold_angle(input logic [32:0] m);
    logic signed [AW-1:0] s;
    fold_t f;
    s = $signed({2'b00, m});
    if (s > DEG180_Q16) s = s - DEG360_Q16;
    f.neg = 1'b0;
    if (s > DEG90_Q16) begin
      s = s - DEG180_Q16;
      f.neg = 1'b1;
    end else if (s < -DEG90_Q16) begin
      s = s + DEG180_Q16;
      f.neg = 1'b1;
    end
    f.ang = s <<< GUARD;
    return f;
  endfunction

  // round half up to Q16 and saturate
  function automatic logic signed [DATA_WIDTH-1:0] round_sat(input logic signed [VW-1:0] v);
    logic signed [VW:0]       t;
    logic signed [VW-GUARD:0] r;
    t = $signed({v[VW-1], v}) + $signed((VW+1)'(128));
    r = t[VW:GUARD];
    if (r > SAT_HI)      round_sat = SAT_HI[DATA_WIDTH-1:0];
    else if (r < SAT_LO) round_sat = SAT_LO[DATA_WIDTH-1:0];
    else                 round_sat = r[DATA_WIDTH-1:0];
  endfunction

endpackage

// ===== rtl/core/spherical_coordinate_converter_unit.sv =====
// Top level of the spherical / cartesian coordinate converter.
//
// Input channel coord_valid / coord_stall / coord carries one triple in
// signed Q16.16 and a count of given values; result_valid / result_stall /
// result returns one converted triple per item, rounded and saturated.
// mode_wr_en / mode_wr_data writes the mode: 0 polar to cartesian (degrees),
// 1 cartesian to polar. Write it only while no item is in flight.
// Stages: input set-up and mod-360 reduction, three gain multipliers,
// two CORDIC passes of one registered micro-rotation per stage and the
// output register. Throughput is one item per cycle while result_stall
// is low; every stage is a register with its own valid, so items stream
// back to back.
// When result_stall is high the output holds; bubbles further up still
// close, and coord_stall rises only once every stage holds an item.
// Synchronous reset empties the pipeline and sets mode to polar to
// cartesian.
`timescale 1ns / 1ps
module spherical_coordinate_converter_unit import scc_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    mode_wr_en,
  input  logic    mode_wr_data,
  input  logic    coord_valid,
  output logic    coord_stall,
  input  coord_t  coord,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  mode_t mode;
  logic  prep_ready;
  logic  pv, dg1_ready, dg2_ready, dg3_ready, fin_ready;
  work_t pw;
  logic  c1_valid [0:CORDIC_STAGES];
  logic  c1_ready [0:CORDIC_STAGES];
  work_t c1_work  [0:CORDIC_STAGES];
  logic  c2_valid [0:CORDIC_STAGES];
  logic  c2_ready [0:CORDIC_STAGES];
  work_t c2_work  [0:CORDIC_STAGES];
  logic  d3_valid;
  work_t d3_work;

  always_ff @(posedge clk) begin
    if (rst) mode <= MODE_P2C;
    else if (mode_wr_en) mode <= mode_t'(mode_wr_data);
  end

  assign coord_stall = !prep_ready;

  scc_prep u_prep (
    .clk, .rst, .mode,
    .in_valid (coord_valid), .in_ready (prep_ready), .in_item (coord),
    .out_valid (pv), .out_ready (dg1_ready), .out_work (pw)
  );

  scc_degain #(.STEP(DG_PRE)) u_dg1 (
    .clk, .rst,
    .in_valid (pv), .in_ready (dg1_ready), .in_work (pw),
    .out_valid (c1_valid[0]), .out_ready (c1_ready[0]), .out_work (c1_work[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_pass1
    scc_cordic_stage #(.SHIFT(i)) u_stage (
      .clk, .rst,
      .in_valid (c1_valid[i]), .in_ready (c1_ready[i]), .in_work (c1_work[i]),
      .out_valid (c1_valid[i+1]), .out_ready (c1_ready[i+1]),
      .out_work (c1_work[i+1])
    );
  end

  assign c1_ready[CORDIC_STAGES] = dg2_ready;

  scc_degain #(.STEP(DG_MID)) u_dg2 (
    .clk, .rst,
    .in_valid (c1_valid[CORDIC_STAGES]), .in_ready (dg2_ready),
    .in_work (c1_work[CORDIC_STAGES]),
    .out_valid (c2_valid[0]), .out_ready (c2_ready[0]), .out_work (c2_work[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_pass2
    scc_cordic_stage #(.SHIFT(i)) u_stage (
      .clk, .rst,
      .in_valid (c2_valid[i]), .in_ready (c2_ready[i]), .in_work (c2_work[i]),
      .out_valid (c2_valid[i+1]), .out_ready (c2_ready[i+1]),
      .out_work (c2_work[i+1])
    );
  end

  assign c2_ready[CORDIC_STAGES] = dg3_ready;

  scc_degain #(.STEP(DG_POST)) u_dg3 (
    .clk, .rst,
    .in_valid (c2_valid[CORDIC_STAGES]), .in_ready (dg3_ready),
    .in_work (c2_work[CORDIC_STAGES]),
    .out_valid (d3_valid), .out_ready (fin_ready), .out_work (d3_work)
  );

  scc_finish u_fin (
    .clk, .rst,
    .in_valid (d3_valid), .in_ready (fin_ready), .in_work (d3_work),
    .out_valid (result_valid), .out_stall (result_stall), .out_item (result)
  );

endmodule

// ===== rtl/core/scc_prep.sv =====
// Input stage: defaults, angle reduction mod 360 and CORDIC set-up.
`timescale 1ns / 1ps
module scc_prep import scc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  mode_t  mode,
  input  logic   in_valid,
  output logic   in_ready,
  input  coord_t in_item,
  output logic   out_valid,
  input  logic   out_ready,
  output work_t  out_work
);

  localparam int NRED = 4;

  function automatic logic [32:0] mod_step(input logic [32:0] u, input int k);
    logic [32:0] d;
    d = DEG360_U << k;
    return (u >= d) ? u - d : u;
  endfunction

  logic  p_valid [0:NRED];
  prep_t p_data  [0:NRED];
  logic  rdy     [0:NRED+1];
  prep_t p0_next;
  work_t w_next;
  fold_t fa, fb;
  logic signed [VW-1:0] xx, yy, zz;

  assign rdy[NRED+1] = !out_valid || out_ready;
  assign in_ready    = rdy[0];

  always_comb begin
    p0_next      = '0;
    p0_next.mode = mode;
    p0_next.a    = (in_item.values_given > 2'd0) ? in_item.coord_a : '0;
    p0_next.b    = (in_item.values_given > 2'd1) ? in_item.coord_b : '0;
    if (in_item.values_given > 2'd2) p0_next.c = in_item.coord_c;
    else p0_next.c = (mode == MODE_P2C) ? ONE_Q16 : '0;
    p0_next.ua = {p0_next.a[DATA_WIDTH-1], p0_next.a} + RED_OFFSET;
    p0_next.ub = {p0_next.b[DATA_WIDTH-1], p0_next.b} + RED_OFFSET;
  end

  assign rdy[0] = !p_valid[0] || rdy[1];

  always_ff @(posedge clk) begin
    if (rst) p_valid[0] <= 1'b0;
    else if (rdy[0]) p_valid[0] <= in_valid;
    if (rdy[0] && in_valid) p_data[0] <= p0_next;
  end

  // two restoring steps per stage, quotient bits 7 down to 0
  for (genvar s = 1; s <= NRED; s++) begin : g_red
    prep_t nx;
    assign rdy[s] = !p_valid[s] || rdy[s+1];
    always_comb begin
      nx    = p_data[s-1];
      nx.ua = mod_step(mod_step(p_data[s-1].ua, 9 - 2*s), 8 - 2*s);
      nx.ub = mod_step(mod_step(p_data[s-1].ub, 9 - 2*s), 8 - 2*s);
    end
    always_ff @(posedge clk) begin
      if (rst) p_valid[s] <= 1'b0;
      else if (rdy[s]) p_valid[s] <= p_valid[s-1];
      if (rdy[s] && p_valid[s-1]) p_data[s] <= nx;
    end
  end

  always_comb begin
    fa = fold_angle(p_data[NRED].ua);
    fb = fold_angle(p_data[NRED].ub);
    xx = {{(VW-DATA_WIDTH-GUARD){p_data[NRED].a[DATA_WIDTH-1]}}, p_data[NRED].a, 8'h00};
    yy = {{(VW-DATA_WIDTH-GUARD){p_data[NRED].b[DATA_WIDTH-1]}}, p_data[NRED].b, 8'h00};
    zz = {{(VW-DATA_WIDTH-GUARD){p_data[NRED].c[DATA_WIDTH-1]}}, p_data[NRED].c, 8'h00};
    w_next      = '0;
    w_next.mode = p_data[NRED].mode;
    if (p_data[NRED].mode == MODE_P2C) begin
      w_next.x    = zz;
      w_next.z    = fb.ang;
      w_next.neg1 = fb.neg;
      w_next.ang2 = fa.ang;
      w_next.neg2 = fa.neg;
    end else begin
      w_next.hold = zz;
      w_next.skip = (xx == '0) && (yy == '0);
      if (yy[VW-1]) begin
        // lower half plane: turn by half a revolution first
        w_next.x = -yy;
        w_next.y = -xx;
        w_next.z = xx[VW-1] ? -DEG180_Q24 : DEG180_Q24;
      end else begin
        w_next.x = yy;
        w_next.y = xx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (rdy[NRED+1]) out_valid <= p_valid[NRED];
    if (rdy[NRED+1] && p_valid[NRED]) out_work <= w_next;
  end

endmodule

// ===== rtl/core/scc_degain.sv =====
// Two-stage CORDIC gain correction with per-position set-up of the next pass.
`timescale 1ns / 1ps
module scc_degain import scc_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  work_t in_work,
  output logic  out_valid,
  input  logic  out_ready,
  output work_t out_work
);

  logic                a_valid;
  work_t               a_work;
  logic                a_neg;
  logic [VW-1:0]       a_hi;
  logic [2*KW-1:0]     a_lo;
  logic                a_ready, b_ready;
  logic [VW-1:0]       mag_in;
  logic [VW-1:0]       mag;
  logic signed [VW-1:0] dg, h;
  work_t               b_next;

  assign b_ready  = !out_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;
  assign mag_in   = in_work.x[VW-1] ? VW'(-in_work.x) : VW'(in_work.x);

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (a_ready) a_valid <= in_valid;
    if (a_ready && in_valid) begin
      a_work <= in_work;
      a_neg  <= in_work.x[VW-1];
      a_hi   <= {{KW{1'b0}}, mag_in[VW-1:KW]} * {{(VW-KW){1'b0}}, INV_GAIN};
      a_lo   <= {{KW{1'b0}}, mag_in[KW-1:0]} * {{KW{1'b0}}, INV_GAIN};
    end
  end

  always_comb begin
    mag    = a_hi + {{(VW-KW){1'b0}}, a_lo[2*KW-1:KW]};
    dg     = a_neg ? -$signed(mag) : $signed(mag);
    h      = a_work.skip ? '0 : dg;
    b_next = a_work;
    if (STEP == DG_PRE) begin
      if (a_work.mode == MODE_P2C) b_next.x = a_work.neg1 ? -dg : dg;
    end else if (STEP == DG_MID) begin
      if (a_work.mode == MODE_P2C) begin
        b_next.hold = a_work.y;
        b_next.x    = a_work.neg2 ? -dg : dg;
        b_next.y    = '0;
        b_next.z    = a_work.ang2;
      end else begin
        b_next.az   = a_work.skip ? '0 : a_work.z;
        b_next.x    = h;
        b_next.y    = a_work.hold;
        b_next.z    = '0;
        b_next.skip = (h == '0) && (a_work.hold == '0);
      end
    end else begin
      if (a_work.mode == MODE_C2P) begin
        b_next.x = h;
        b_next.z = a_work.skip ? '0 : a_work.z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (b_ready) out_valid <= a_valid;
    if (b_ready && a_valid) out_work <= b_next;
  end

endmodule

// ===== rtl/core/scc_cordic_stage.sv =====
// One registered CORDIC micro-rotation, rotation or vectoring by item mode.
`timescale 1ns / 1ps
module scc_cordic_stage import scc_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  work_t in_work,
  output logic  out_valid,
  input  logic  out_ready,
  output work_t out_work
);

  logic                 plus;
  logic signed [VW-1:0] dx, dy;
  logic signed [AW-1:0] at;
  work_t                nx;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    // rotation drives z to zero, vectoring drives y to zero
    plus = (in_work.mode == MODE_P2C) ? !in_work.z[AW-1] : in_work.y[VW-1];
    dx   = in_work.y >>> SHIFT;
    dy   = in_work.x >>> SHIFT;
    at   = $signed({{(AW-30){1'b0}}, ATAN_TAB[SHIFT]});
    nx   = in_work;
    if (plus) begin
      nx.x = in_work.x - dx;
      nx.y = in_work.y + dy;
      nx.z = in_work.z - at;
    end else begin
      nx.x = in_work.x + dx;
      nx.y = in_work.y - dy;
      nx.z = in_work.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (in_ready) out_valid <= in_valid;
    if (in_ready && in_valid) out_work <= nx;
  end

endmodule

// ===== rtl/core/scc_finish.sv =====
// Output register: result mapping, rounding and saturation.
`timescale 1ns / 1ps
module scc_finish import scc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  work_t   in_work,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_item
);

  result_t nx;

  assign in_ready = !out_valid || !out_stall;

  always_comb begin
    if (in_work.mode == MODE_P2C) begin
      nx.out_a = round_sat(in_work.y);
      nx.out_b = round_sat(in_work.x);
      nx.out_c = round_sat(in_work.hold);
    end else begin
      nx.out_a = round_sat(VW'(in_work.az));
      nx.out_b = round_sat(VW'(in_work.z));
      nx.out_c = round_sat(in_work.x);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (in_ready) out_valid <= in_valid;
    if (in_ready && in_valid) out_item <= nx;
  end

endmodule

// ===== rtl/core/scc_checker.sv =====
// Port-level checks for the converter, bound to the top level.
`timescale 1ns / 1ps
module scc_checker import scc_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    coord_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // and does not change
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result))
    else $error("result changed while stalled");

  // input backs up only behind a full, stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    coord_stall |-> result_valid && result_stall)
    else $error("input stalled with output free");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind spherical_coordinate_converter_unit scc_checker u_scc_checker (.*);

// ===== verif/tb.sv =====
// Self-checking testbench for the spherical / cartesian coordinate converter.
`timescale 1ns / 1ps
module tb;
  import scc_pkg::*;

  localparam int STAGES    = 16;
  localparam int LATENCY   = 13 + 2 * STAGES;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 2000;

  localparam longint DEG90_L  = 64'sd90 * 65536;
  localparam longint DEG180_L = 64'sd180 * 65536;
  localparam longint DEG360_L = 64'sd360 * 65536;
  localparam longint INV_K    = 64'd652032874;

  localparam longint ATAN_DEG [0:31] = '{
    754974720, 445687602, 235489089, 119537938, 60000934, 30029717,
    15018523, 7509719, 3754917, 1877466, 938734, 469367, 234684, 117342,
    58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
    14, 7, 4, 2, 1, 0
  };

  logic    clk;
  logic    rst;
  logic    mode_wr_en;
  logic    mode_wr_data;
  logic    coord_valid;
  logic    coord_stall;
  coord_t  coord;
  logic    result_valid;
  logic    result_stall;
  result_t result;

  spherical_coordinate_converter_unit #(.CORDIC_STAGES(STAGES)) uut (
    .clk(clk), .rst(rst),
    .mode_wr_en(mode_wr_en), .mode_wr_data(mode_wr_data),
    .coord_valid(coord_valid), .coord_stall(coord_stall), .coord(coord),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  mode_t   conv_mode;
  coord_t  pending_coords [$];
  result_t expected_results [$];
  int      send_idle_pct;
  int      stall_pct;
  int      n_errors;
  int      wdog;

  // arithmetic shift toward minus infinity, matches >>> on longint
  function automatic longint ashr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic signed [31:0] round_q16(longint v);
    longint r;
    r = ashr(v + 128, 8);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic longint scale_by_inv_gain(longint a);
    longint unsigned m, r;
    m = (a < 0) ? longint'(-a) : a;
    r = (m >> 30) * INV_K + (((m & 64'h3FFF_FFFF) * INV_K) >> 30);
    return (a < 0) ? -longint'(r) : longint'(r);
  endfunction

  task automatic rotate(input longint mag, input longint ang, output longint c,
                        output longint s);
    longint m, x, y, z, dx, dy;
    m = ang % DEG360_L;
    if (m < 0) m += DEG360_L;
    if (m > DEG180_L) m -= DEG360_L;
    x = scale_by_inv_gain(mag);
    y = 0;
    if (m > DEG90_L) begin
      m -= DEG180_L; x = -x;
    end else if (m < -DEG90_L) begin
      m += DEG180_L; x = -x;
    end
    z = m * 256;
    for (int i = 0; i < STAGES; i++) begin
      dx = ashr(y, i); dy = ashr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_DEG[i];
      end else begin
        x += dx; y -= dy; z += ATAN_DEG[i];
      end
    end
    c = x; s = y;
  endtask

  task automatic vectorise(inout longint x, inout longint y, output longint ang);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = ashr(y, i); dy = ashr(x, i);
      if (y < 0) begin
        x -= dx; y += dy; z -= ATAN_DEG[i];
      end else begin
        x += dx; y -= dy; z += ATAN_DEG[i];
      end
    end
    ang = z;
  endtask

  task automatic convert_coords(input coord_t in, output result_t res);
    longint a, b, c, h, x, y, z, bx, by, az, el, r, vx, vy, base, ang;
    a = (in.values_given > 0) ? longint'(in.coord_a) : 0;
    b = (in.values_given > 1) ? longint'(in.coord_b) : 0;
    if (conv_mode == MODE_P2C) begin
      c = (in.values_given > 2) ? longint'(in.coord_c) : 65536;
      rotate(c * 256, b, h, z);
      rotate(h, a, y, x);
      res.out_a = round_q16(x);
      res.out_b = round_q16(y);
      res.out_c = round_q16(z);
    end else begin
      c = (in.values_given > 2) ? longint'(in.coord_c) : 0;
      bx = a * 256; by = b * 256; z = c * 256;
      az = 0; el = 0; h = 0; r = 0;
      if (bx != 0 || by != 0) begin
        base = 0;
        if (by < 0) begin
          vx = -by; vy = -bx;
          base = (bx >= 0) ? DEG180_L * 256 : -DEG180_L * 256;
        end else begin
          vx = by; vy = bx;
        end
        vectorise(vx, vy, ang);
        az = base + ang;
        h = scale_by_inv_gain(vx);
      end
      if (h != 0 || z != 0) begin
        vx = h; vy = z;
        vectorise(vx, vy, el);
        r = scale_by_inv_gain(vx);
      end
      res.out_a = round_q16(az);
      res.out_b = round_q16(el);
      res.out_c = round_q16(r);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("error at %0t: %s got %08h expected %08h", $realtime, what, got, want);
    n_errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      coord_valid <= 1'b0;
    end else if (!coord_valid || !coord_stall) begin
      if (pending_coords.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        coord       <= pending_coords.pop_front();
        coord_valid <= 1'b1;
      end else begin
        coord_valid <= 1'b0;
      end
    end
  end

  // prediction at acceptance
  always @(posedge clk) begin
    result_t r;
    if (!rst && coord_valid && !coord_stall) begin
      convert_coords(coord, r);
      expected_results.push_back(r);
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected item", result[95:64], 32'h0);
      end else begin
        want = expected_results.pop_front();
        if (result.out_a !== want.out_a) report_mismatch("out_a", result.out_a, want.out_a);
        if (result.out_b !== want.out_b) report_mismatch("out_b", result.out_b, want.out_b);
        if (result.out_c !== want.out_c) report_mismatch("out_c", result.out_c, want.out_c);
      end
    end
    result_stall <= rst ? 1'b0 : ($urandom_range(99) < stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (coord_valid && !coord_stall) || (result_valid && !result_stall))
      wdog <= 0;
    else
      wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("spherical_coordinate_converter_unit: mismatch");
      $finish;
    end
  end

  function automatic logic [31:0] rand_field();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1: return 32'($signed($urandom_range(400)) - 200) << 16;
      2: return 32'($signed($urandom_range(2000)) - 1000) << 12;
      3: return 32'($signed($urandom_range(64)) - 32);
      default: return $urandom;
    endcase
  endfunction

  function automatic coord_t make_coord(logic [31:0] a, logic [31:0] b,
                                        logic [31:0] c, logic [1:0] n);
    coord_t t;
    t.coord_a = a; t.coord_b = b; t.coord_c = c; t.values_given = n;
    return t;
  endfunction

  task automatic wait_drained();
    while (pending_coords.size() > 0 || coord_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic set_mode(input mode_t m);
    mode_wr_en   <= 1'b1;
    mode_wr_data <= m;
    @(posedge clk);
    mode_wr_en   <= 1'b0;
    conv_mode = m;
  endtask

  task automatic load_directed();
    logic [31:0] ext [4];
    ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
    for (int n = 0; n < 4; n++)
      pending_coords.push_back(make_coord(32'h5A << 16, 32'h1E << 16, 32'h3 << 16,
                                          2'(n)));
    pending_coords.push_back(make_coord(32'h0, 32'h0, 32'h0, 2'd3));
    pending_coords.push_back(make_coord(32'h0, 32'h0, 32'h0002_0000, 2'd3));
    pending_coords.push_back(make_coord(32'h00B4_0000, 32'hFFA6_0000, 32'h0001_0000, 2'd3));
    pending_coords.push_back(make_coord(32'hFF4C_0000, 32'h0, 32'hFFFF_0000, 2'd3));
    pending_coords.push_back(make_coord(32'h0001_0000, 32'hFFFF_0000, 32'h0, 2'd2));
    pending_coords.push_back(make_coord(32'hFFFF_0000, 32'hFFFF_0000, 32'h0, 2'd2));
    pending_coords.push_back(make_coord(32'hFFFF_0000, 32'h0, 32'h0, 2'd2));
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 3; j++)
        pending_coords.push_back(make_coord(ext[i], ext[(i + j) % 4], ext[j], 2'd3));
  endtask

  task automatic run_phase(input mode_t m, input int idle, input int stall, input int n);
    set_mode(m);
    send_idle_pct = idle;
    stall_pct     = stall;
    if (n == 0) load_directed();
    for (int i = 0; i < n; i++)
      pending_coords.push_back(make_coord(rand_field(), rand_field(), rand_field(),
                                          2'($urandom_range(3))));
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    mode_wr_en = 1'b0; mode_wr_data = 1'b0;
    coord_valid = 1'b0; coord = '0; result_stall = 1'b0;
    conv_mode = MODE_P2C;
    send_idle_pct = 0; stall_pct = 0; n_errors = 0; wdog = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_phase(MODE_P2C, 0, 0, 0);
    run_phase(MODE_C2P, 0, 0, 0);
    run_phase(MODE_P2C, 0, 0, N_RANDOM / 8);
    run_phase(MODE_C2P, 0, 0, N_RANDOM / 8);
    run_phase(MODE_P2C, 48, 0, N_RANDOM / 8);
    run_phase(MODE_C2P, 48, 0, N_RANDOM / 8);
    run_phase(MODE_P2C, 0, 48, N_RANDOM / 8);
    run_phase(MODE_C2P, 0, 48, N_RANDOM / 8);
    run_phase(MODE_P2C, 10, 10, N_RANDOM / 8);
    run_phase(MODE_C2P, 10, 10, N_RANDOM / 8);
    if (n_errors == 0)
      $display("spherical_coordinate_converter_unit: match");
    else
      $display("spherical_coordinate_converter_unit: mismatch");
    $finish;
  end
endmodule
